// ----- hdl/bpmt_pkg.sv -----
// ----------------------------------------------------------------------------
// bpmt_pkg: shared types for the best pair match table
// Field widths, request codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bpmt_pkg;

    localparam int IDX_W  = 6;
    localparam int X_W    = 12;
    localparam int ANG_W  = 15;
    localparam int COST_W = 17;
    localparam int ENT_W  = IDX_W + COST_W;

    typedef enum logic [1:0] {
        REQ_PROPOSE = 2'd0,
        REQ_READ    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_RSVD    = 2'd3
    } req_t;

    typedef struct packed {
        logic capture;
        logic cost_en;
        logic commit;
        logic write_j;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic propose_go;
        logic pair_wins;
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/bpmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpmt_ctrl: request sequencer
// One-hot state machine that steps one word through capture, cost, and for
// a winning proposal commit and second table write, then response.
// ----------------------------------------------------------------------------
module bpmt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output bpmt_pkg::cmd_t cmd,
    input  bpmt_pkg::stat_t stat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_COST = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_WRJ  = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COST;
                end
            end
            ST_COST: begin
                cmd.cost_en = 1'b1;
                state_next  = stat.propose_go ? ST_EVAL : ST_RESP;
            end
            ST_EVAL: begin
                if (stat.pair_wins) begin
                    cmd.commit = 1'b1;
                    state_next = ST_WRJ;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_WRJ: begin
                cmd.write_j = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/bpmt_dp.sv -----
// ----------------------------------------------------------------------------
// bpmt_dp: match table datapath
// Request registers, pair cost, matched flags, partner/cost memory and the
// output word register.
// ----------------------------------------------------------------------------
module bpmt_dp #(
    parameter int NUM_BARS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bpmt_pkg::cmd_t                         cmd,
    output bpmt_pkg::stat_t                        stat,
    input  logic [1:0]                             s_req_type,
    input  logic [bpmt_pkg::IDX_W-1:0]             s_first_index,
    input  logic [bpmt_pkg::IDX_W-1:0]             s_second_index,
    input  logic [bpmt_pkg::X_W-1:0]               s_first_x,
    input  logic [bpmt_pkg::X_W-1:0]               s_second_x,
    input  logic signed [bpmt_pkg::ANG_W-1:0]      s_first_angle,
    input  logic signed [bpmt_pkg::ANG_W-1:0]      s_second_angle,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_status,
    output logic                                   m_pair_formed,
    output logic                                   m_entry_matched,
    output logic [bpmt_pkg::IDX_W-1:0]             m_entry_partner,
    output logic [bpmt_pkg::COST_W-1:0]            m_entry_cost
);

    localparam int IW     = bpmt_pkg::IDX_W;
    localparam int AW     = bpmt_pkg::ANG_W;
    localparam int CW     = bpmt_pkg::COST_W;
    localparam int EW     = bpmt_pkg::ENT_W;
    localparam int DEPTH  = (NUM_BARS < (1 << IW)) ? NUM_BARS : (1 << IW);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [IW:0] DEPTH_V = (IW + 1)'(DEPTH);

    bpmt_pkg::req_t       req_reg;
    logic [IW-1:0]        i_reg;
    logic [IW-1:0]        j_reg;
    logic signed [AW:0]   d_reg;
    logic                 right_first_reg;
    logic [CW-1:0]        cost_reg;
    logic                 formed_reg;
    logic [EW-1:0]        rd_a_reg;
    logic [EW-1:0]        rd_b_reg;
    logic [DEPTH-1:0]     flags_reg;
    logic [DEPTH-1:0]     flags_next;
    logic [EW-1:0]        entry_mem [DEPTH];

    logic                 m_valid_reg;
    logic                 m_status_reg;
    logic                 m_pair_formed_reg;
    logic                 m_entry_matched_reg;
    logic [IW-1:0]        m_entry_partner_reg;
    logic [CW-1:0]        m_entry_cost_reg;

    logic signed [AW:0]   d_in;
    logic [AW:0]          abs_full;
    logic [AW-1:0]        ad;
    logic                 lr_pos;
    logic [CW-1:0]        cost_calc;
    logic                 i_ok;
    logic                 j_ok;
    logic                 mi;
    logic                 mj;
    logic [IW-1:0]        pa;
    logic [IW-1:0]        pb;
    logic [CW-1:0]        ca;
    logic [CW-1:0]        cb;
    logic                 pa_ok;
    logic                 pb_ok;
    logic                 mem_we;
    logic [ADDR_W-1:0]    wr_addr;
    logic [IW-1:0]        wr_partner;
    logic                 e_matched;
    logic                 e_status;

    assign d_in = {s_first_angle[AW-1], s_first_angle}
                - {s_second_angle[AW-1], s_second_angle};

    // cost = 2*|d| plus |d| again when the left bar leans more than the right
    assign abs_full  = d_reg[AW] ? (AW + 1)'(-d_reg) : (AW + 1)'(d_reg);
    assign ad        = abs_full[AW-1:0];
    assign lr_pos    = right_first_reg ? d_reg[AW] : (!d_reg[AW] && (d_reg != '0));
    assign cost_calc = CW'({ad, 1'b0}) + (lr_pos ? CW'(ad) : '0);

    assign i_ok  = {1'b0, i_reg} < DEPTH_V;
    assign j_ok  = {1'b0, j_reg} < DEPTH_V;
    assign mi    = i_ok && flags_reg[i_reg[ADDR_W-1:0]];
    assign mj    = j_ok && flags_reg[j_reg[ADDR_W-1:0]];
    assign pa    = rd_a_reg[EW-1:CW];
    assign ca    = rd_a_reg[CW-1:0];
    assign pb    = rd_b_reg[EW-1:CW];
    assign cb    = rd_b_reg[CW-1:0];
    assign pa_ok = {1'b0, pa} < DEPTH_V;
    assign pb_ok = {1'b0, pb} < DEPTH_V;

    assign stat.propose_go = (req_reg == bpmt_pkg::REQ_PROPOSE) && (i_reg != j_reg)
                           && i_ok && j_ok;
    assign stat.pair_wins  = (!mi || (cost_reg < ca)) && (!mj || (cost_reg < cb));
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        flags_next = flags_reg;
        if (cmd.cost_en && (req_reg == bpmt_pkg::REQ_CLEAR)) begin
            flags_next = '0;
        end
        if (cmd.commit) begin
            if (mi && pa_ok && (pa != i_reg) && (pa != j_reg)) begin
                flags_next[pa[ADDR_W-1:0]] = 1'b0;
            end
            if (mj && pb_ok && (pb != i_reg) && (pb != j_reg)) begin
                flags_next[pb[ADDR_W-1:0]] = 1'b0;
            end
            flags_next[i_reg[ADDR_W-1:0]] = 1'b1;
            flags_next[j_reg[ADDR_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= '0;
            formed_reg <= 1'b0;
        end else begin
            flags_reg <= flags_next;
            if (cmd.capture) begin
                formed_reg <= 1'b0;
            end else if (cmd.commit) begin
                formed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg         <= bpmt_pkg::req_t'(s_req_type);
            i_reg           <= s_first_index;
            j_reg           <= s_second_index;
            d_reg           <= d_in;
            right_first_reg <= s_first_x > s_second_x;
        end
        if (cmd.cost_en) begin
            cost_reg <= cost_calc;
        end
    end

    // partner/cost table: one write port, two registered read ports
    assign mem_we     = cmd.commit || cmd.write_j;
    assign wr_addr    = cmd.write_j ? j_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign wr_partner = cmd.write_j ? i_reg : j_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[wr_addr] <= {wr_partner, cost_reg};
        end
        if (cmd.capture) begin
            rd_a_reg <= entry_mem[s_first_index[ADDR_W-1:0]];
            rd_b_reg <= entry_mem[s_second_index[ADDR_W-1:0]];
        end
    end

    assign e_matched = i_ok && flags_reg[i_reg[ADDR_W-1:0]];
    assign e_status  = (req_reg == bpmt_pkg::REQ_PROPOSE) && (i_reg == j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg        <= e_status;
            m_pair_formed_reg   <= formed_reg;
            m_entry_matched_reg <= e_matched;
            m_entry_partner_reg <= !e_matched ? '0 : (formed_reg ? j_reg : pa);
            m_entry_cost_reg    <= !e_matched ? '0 : (formed_reg ? cost_reg : ca);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_pair_formed   = m_pair_formed_reg;
    assign m_entry_matched = m_entry_matched_reg;
    assign m_entry_partner = m_entry_partner_reg;
    assign m_entry_cost    = m_entry_cost_reg;

endmodule

// ----- hdl/best_pair_match_table_core.sv -----
// ----------------------------------------------------------------------------
// best_pair_match_table_core: light bar pairing table
// Table of bars with matched flag, partner and cost; propose, read, clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request word per valid/ready handshake: propose a pair
//   (first/second index, x and angle of each), read the entry of first_index,
//   or clear all matches. m_* returns one response word per request: status,
//   pair_formed and the entry of first_index after the request.
//   After accept, read, clear and rejected proposals step through the cost
//   and response states; a losing proposal also passes the evaluate state,
//   and a winning one also the evaluate and second write states. A winning
//   proposal writes two entries through the single write port of the
//   partner/cost memory, one per cycle; one word is in flight at a time.
//   Reset clears all matched flags at once; partner/cost entries are only
//   read behind a set flag. No clearing pass is needed.
//   If the receiver holds m_ready low, the response stays in the output
//   register; the next word is still taken, and the sequencer holds it in
//   its response state until the output register frees.
// ----------------------------------------------------------------------------
module best_pair_match_table_core #(
    parameter int NUM_BARS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [bpmt_pkg::IDX_W-1:0]        s_first_index,
    input  logic [bpmt_pkg::IDX_W-1:0]        s_second_index,
    input  logic [bpmt_pkg::X_W-1:0]          s_first_x,
    input  logic [bpmt_pkg::X_W-1:0]          s_second_x,
    input  logic signed [bpmt_pkg::ANG_W-1:0] s_first_angle,
    input  logic signed [bpmt_pkg::ANG_W-1:0] s_second_angle,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic                              m_pair_formed,
    output logic                              m_entry_matched,
    output logic [bpmt_pkg::IDX_W-1:0]        m_entry_partner,
    output logic [bpmt_pkg::COST_W-1:0]       m_entry_cost
);

    bpmt_pkg::cmd_t  cmd;
    bpmt_pkg::stat_t stat;

    bpmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    bpmt_dp #(
        .NUM_BARS (NUM_BARS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_first_index   (s_first_index),
        .s_second_index  (s_second_index),
        .s_first_x       (s_first_x),
        .s_second_x      (s_second_x),
        .s_first_angle   (s_first_angle),
        .s_second_angle  (s_second_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_pair_formed   (m_pair_formed),
        .m_entry_matched (m_entry_matched),
        .m_entry_partner (m_entry_partner),
        .m_entry_cost    (m_entry_cost)
    );

endmodule

// ----- hdl/bpmt_checker.sv -----
// ----------------------------------------------------------------------------
// bpmt_checker: port-level checks for the best pair match table
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module bpmt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_status,
    input logic                              m_pair_formed,
    input logic                              m_entry_matched,
    input logic [bpmt_pkg::IDX_W-1:0]        m_entry_partner,
    input logic [bpmt_pkg::COST_W-1:0]       m_entry_cost
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("response word dropped while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_unmatched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_entry_matched |-> (m_entry_partner == '0) && (m_entry_cost == '0))
        else $error("unmatched entry returns nonzero fields");

    a_ignored_not_formed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_pair_formed)
        else $error("ignored proposal reports a formed pair");

    a_formed_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pair_formed |-> m_entry_matched)
        else $error("formed pair leaves first bar unmatched");

endmodule

bind best_pair_match_table_core bpmt_checker u_bpmt_checker (.*);
